>>> rtl/rgbcfs_pkg.sv
// shared types, constants and helpers of the rgb colour fade sequencer
package rgbcfs_pkg;

	// sizes fixed by the register map and the item fields
	localparam int MAX_COLORS        = 5;
	localparam int TABLE_WORDS       = 5;
	localparam int LEVEL_W           = 8;
	localparam int INDEX_W           = 3;
	localparam int CFG_INTERVAL_W    = 16;
	localparam int COLOR_W           = 3 * LEVEL_W;
	localparam int CFG_ADDR_W        = 5;
	localparam int CFG_DATA_W        = 32;
	localparam int INTERVAL_BITS_DEF = 16;

	// register reset values
	localparam logic [CFG_INTERVAL_W-1:0] FADE_INTERVAL_RST = 16'd10;
	localparam logic [CFG_INTERVAL_W-1:0] HOLD_INTERVAL_RST = 16'd1000;
	localparam logic [INDEX_W-1:0]        COLOR_COUNT_RST   = 3'd5;
	localparam logic [TABLE_WORDS-1:0][COLOR_W-1:0] COLOR_WORD_RST = {
		24'hFFFFFF, 24'hFFFF00, 24'h0000FF, 24'h00FF00, 24'hFF0000
	};

	// register index, taken from the word address
	typedef enum logic [2:0] {
		REG_FADE_INTERVAL = 3'd0,
		REG_HOLD_INTERVAL = 3'd1,
		REG_COLOR_COUNT   = 3'd2,
		REG_COLOR_WORD_0  = 3'd3,
		REG_COLOR_WORD_1  = 3'd4,
		REG_COLOR_WORD_2  = 3'd5,
		REG_COLOR_WORD_3  = 3'd6,
		REG_COLOR_WORD_4  = 3'd7
	} reg_idx_t;

	// input item: tick or interact event
	typedef struct packed {
		logic              func;
		logic signed [7:0] signal_code;
	} in_item_t;

	// result item: levels after the step
	typedef struct packed {
		logic [LEVEL_W-1:0] red_duty;
		logic [LEVEL_W-1:0] green_duty;
		logic [LEVEL_W-1:0] blue_duty;
		logic [INDEX_W-1:0] current_index;
		logic               at_target;
	} out_item_t;

	// one level moves a single step towards its target
	function automatic logic [LEVEL_W-1:0] step_toward(
		input logic [LEVEL_W-1:0] lvl,
		input logic [LEVEL_W-1:0] tgt
	);
		logic [LEVEL_W-1:0] res;
		if (lvl < tgt) begin
			res = lvl + LEVEL_W'(1);
		end else if (lvl > tgt) begin
			res = lvl - LEVEL_W'(1);
		end else begin
			res = lvl;
		end
		return res;
	endfunction

endpackage

>>> rtl/rgb_color_fade_sequencer.sv
// rgb colour fade sequencer: input register, step logic, result register, apb registers
// path: an item is held in the input register, then stepped into the result register, which offers it
// throughput: one item per cycle unless results stall, set by the single step pass between the registers
// the step state (levels, index, black flag, elapsed counter) updates as each item leaves the input stage
// reset: levels, index, black flag and counter clear, registers take their documented defaults
// pipeline valid flags clear on reset; payload registers are not reset
module rgb_color_fade_sequencer #(
	parameter int INTERVAL_BITS = rgbcfs_pkg::INTERVAL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  rgbcfs_pkg::in_item_t               in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output rgbcfs_pkg::out_item_t              out_data,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [rgbcfs_pkg::CFG_ADDR_W-1:0]  paddr,
	input  logic [rgbcfs_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [rgbcfs_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                               pready
);
	import rgbcfs_pkg::*;

	localparam int CMP_W = (INTERVAL_BITS > CFG_INTERVAL_W) ? INTERVAL_BITS : CFG_INTERVAL_W;

	// configuration registers
	logic [CFG_INTERVAL_W-1:0]           fade_interval_q;
	logic [CFG_INTERVAL_W-1:0]           hold_interval_q;
	logic [INDEX_W-1:0]                  color_count_q;
	logic [TABLE_WORDS-1:0][COLOR_W-1:0] color_word_q;

	// step state
	logic [LEVEL_W-1:0]       red_q, green_q, blue_q;
	logic [INDEX_W-1:0]       index_q;
	logic                     black_q;
	logic [INTERVAL_BITS-1:0] elapsed_q;

	// pipeline registers
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_q;

	logic     wr_en;
	reg_idx_t reg_sel;
	logic     advance;
	logic     fire;

	logic [INDEX_W-1:0]       cnt;
	logic [COLOR_W-1:0]       tgt_cur;
	logic [COLOR_W-1:0]       tgt_next;
	logic                     on_cur;
	logic [INTERVAL_BITS-1:0] elapsed_inc;
	logic [INTERVAL_BITS-1:0] elapsed_nx;
	logic [INDEX_W:0]         index_up;
	logic [INDEX_W-1:0]       index_nx;
	logic                     black_nx;
	logic                     do_fade;
	logic [LEVEL_W-1:0]       red_nx, green_nx, blue_nx;

	// apb port
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fade_interval_q <= FADE_INTERVAL_RST;
			hold_interval_q <= HOLD_INTERVAL_RST;
			color_count_q   <= COLOR_COUNT_RST;
			color_word_q    <= COLOR_WORD_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_FADE_INTERVAL: fade_interval_q <= pwdata[CFG_INTERVAL_W-1:0];
				REG_HOLD_INTERVAL: hold_interval_q <= pwdata[CFG_INTERVAL_W-1:0];
				REG_COLOR_COUNT:   color_count_q   <= pwdata[INDEX_W-1:0];
				REG_COLOR_WORD_0:  color_word_q[0] <= pwdata[COLOR_W-1:0];
				REG_COLOR_WORD_1:  color_word_q[1] <= pwdata[COLOR_W-1:0];
				REG_COLOR_WORD_2:  color_word_q[2] <= pwdata[COLOR_W-1:0];
				REG_COLOR_WORD_3:  color_word_q[3] <= pwdata[COLOR_W-1:0];
				REG_COLOR_WORD_4:  color_word_q[4] <= pwdata[COLOR_W-1:0];
				default: ;
			endcase
		end
	end

	// register read back
	always_comb begin
		unique case (reg_sel)
			REG_FADE_INTERVAL: prdata = CFG_DATA_W'(fade_interval_q);
			REG_HOLD_INTERVAL: prdata = CFG_DATA_W'(hold_interval_q);
			REG_COLOR_COUNT:   prdata = CFG_DATA_W'(color_count_q);
			REG_COLOR_WORD_0:  prdata = CFG_DATA_W'(color_word_q[0]);
			REG_COLOR_WORD_1:  prdata = CFG_DATA_W'(color_word_q[1]);
			REG_COLOR_WORD_2:  prdata = CFG_DATA_W'(color_word_q[2]);
			REG_COLOR_WORD_3:  prdata = CFG_DATA_W'(color_word_q[3]);
			REG_COLOR_WORD_4:  prdata = CFG_DATA_W'(color_word_q[4]);
			default:           prdata = '0;
		endcase
	end

	// handshake: input stage moves on when the result register is free or being taken
	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// colour count clamped into 1..MAX_COLORS
	always_comb begin
		if (color_count_q == '0) begin
			cnt = INDEX_W'(1);
		end else if (color_count_q > INDEX_W'(MAX_COLORS)) begin
			cnt = INDEX_W'(MAX_COLORS);
		end else begin
			cnt = color_count_q;
		end
	end

	// target of the current index
	always_comb begin
		tgt_cur = '0;
		if (!black_q && index_q < INDEX_W'(TABLE_WORDS)) begin
			tgt_cur = color_word_q[index_q];
		end
	end

	assign on_cur = (red_q == tgt_cur[23:16]) && (green_q == tgt_cur[15:8])
		&& (blue_q == tgt_cur[7:0]);

	// saturating tick count
	assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + INTERVAL_BITS'(1);
	assign index_up    = {1'b0, index_q} + (INDEX_W+1)'(1);

	// step decision
	always_comb begin
		elapsed_nx = elapsed_q;
		index_nx   = index_q;
		black_nx   = black_q;
		do_fade    = 1'b0;
		if (!item_s1.func) begin
			elapsed_nx = elapsed_inc;
			if (!on_cur) begin
				if (CMP_W'(elapsed_inc) >= CMP_W'(fade_interval_q)) begin
					do_fade    = 1'b1;
					elapsed_nx = '0;
				end
			end else if (CMP_W'(elapsed_inc) >= CMP_W'(hold_interval_q)) begin
				index_nx   = (index_up >= {1'b0, cnt}) ? '0 : index_up[INDEX_W-1:0];
				black_nx   = 1'b0;
				do_fade    = 1'b1;
				elapsed_nx = '0;
			end
		end else if (item_s1.signal_code == '0) begin
			black_nx = 1'b1;
			if (index_q == '0 || index_q > cnt) begin
				index_nx = cnt - INDEX_W'(1);
			end else begin
				index_nx = index_q - INDEX_W'(1);
			end
		end
	end

	// target after the step; equals the current one on a plain fade step
	always_comb begin
		tgt_next = '0;
		if (!black_nx && index_nx < INDEX_W'(TABLE_WORDS)) begin
			tgt_next = color_word_q[index_nx];
		end
	end

	// levels after the step
	always_comb begin
		red_nx   = red_q;
		green_nx = green_q;
		blue_nx  = blue_q;
		if (do_fade) begin
			red_nx   = step_toward(red_q, tgt_next[23:16]);
			green_nx = step_toward(green_q, tgt_next[15:8]);
			blue_nx  = step_toward(blue_q, tgt_next[7:0]);
		end
	end

	// input stage valid and step state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			red_q       <= '0;
			green_q     <= '0;
			blue_q      <= '0;
			index_q     <= '0;
			black_q     <= 1'b0;
			elapsed_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (fire) begin
				red_q     <= red_nx;
				green_q   <= green_nx;
				blue_q    <= blue_nx;
				index_q   <= index_nx;
				black_q   <= black_nx;
				elapsed_q <= elapsed_nx;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
		if (fire) begin
			out_q.red_duty      <= red_nx;
			out_q.green_duty    <= green_nx;
			out_q.blue_duty     <= blue_nx;
			out_q.current_index <= index_nx;
			out_q.at_target     <= (red_nx == tgt_next[23:16])
				&& (green_nx == tgt_next[15:8]) && (blue_nx == tgt_next[7:0]);
		end
	end

endmodule

>>> tb/sv/rgb_color_fade_sequencer_chk.sv
// checker for the rgb colour fade sequencer: tracks fader state from the transfers and compares
module rgb_color_fade_sequencer_chk (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  rgbcfs_pkg::in_item_t                in_data,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  rgbcfs_pkg::out_item_t               out_data,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic                                pready,
	input  logic [rgbcfs_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [rgbcfs_pkg::CFG_DATA_W-1:0]   pwdata,
	output int                                  results_seen,
	output int                                  error_count
);
	timeunit 1ns;
	timeprecision 1ps;
	import rgbcfs_pkg::*;

	localparam logic                    FUNC_TICK   = 1'b0;
	localparam logic signed [7:0]       CODE_RETRY  = 8'sd0;
	localparam logic [INTERVAL_BITS_DEF-1:0] ELAPSED_TOP = '1;
	localparam int                      PRINT_CAP   = 40;

	// copy of the register file
	logic [CFG_INTERVAL_W-1:0] fade_ms;
	logic [CFG_INTERVAL_W-1:0] hold_ms;
	logic [INDEX_W-1:0]        count_reg;
	logic [COLOR_W-1:0]        palette [TABLE_WORDS];

	// copy of the fader state
	logic [LEVEL_W-1:0]           lvl_r;
	logic [LEVEL_W-1:0]           lvl_g;
	logic [LEVEL_W-1:0]           lvl_b;
	logic [INDEX_W-1:0]           idx;
	logic                         black;
	logic [INTERVAL_BITS_DEF-1:0] elapsed;

	out_item_t levels_due [$];
	int        checked;
	int        bad_total = 0;

	assign error_count = bad_total;

	// colour the levels are heading for: black or the live table word
	function automatic logic [COLOR_W-1:0] aim_color();
		if (black || idx >= TABLE_WORDS) begin
			return '0;
		end
		return palette[idx];
	endfunction

	function automatic logic on_aim();
		return {lvl_r, lvl_g, lvl_b} == aim_color();
	endfunction

	function automatic logic [LEVEL_W-1:0] nudge(logic [LEVEL_W-1:0] cur, logic [LEVEL_W-1:0] aim);
		if (cur < aim) begin
			return cur + 1'b1;
		end
		if (cur > aim) begin
			return cur - 1'b1;
		end
		return cur;
	endfunction

	task automatic fade_once();
		logic [COLOR_W-1:0] c;
		c = aim_color();
		lvl_r = nudge(lvl_r, c[3*LEVEL_W-1:2*LEVEL_W]);
		lvl_g = nudge(lvl_g, c[2*LEVEL_W-1:LEVEL_W]);
		lvl_b = nudge(lvl_b, c[LEVEL_W-1:0]);
	endtask

	// advance the fader by one input item and queue the levels it leaves
	task automatic apply_item(in_item_t it);
		int        lim;
		int        nx;
		out_item_t res;
		lim = int'(count_reg);
		if (lim < 1) lim = 1;
		if (lim > MAX_COLORS) lim = MAX_COLORS;
		if (it.func == FUNC_TICK) begin
			if (elapsed != ELAPSED_TOP) elapsed = elapsed + 1'b1;
			if (!on_aim()) begin
				if (elapsed >= fade_ms) begin
					fade_once();
					elapsed = '0;
				end
			end else if (elapsed >= hold_ms) begin
				nx = idx + 1;
				idx = (nx >= lim) ? '0 : INDEX_W'(nx);
				black = 1'b0;
				fade_once();
				elapsed = '0;
			end
		end else if (it.signal_code == CODE_RETRY) begin
			// fade to black and step back so the same colour comes round again
			black = 1'b1;
			if (idx == 0 || idx > lim) begin
				idx = INDEX_W'(lim - 1);
			end else begin
				idx = idx - 1'b1;
			end
		end
		res.red_duty      = lvl_r;
		res.green_duty    = lvl_g;
		res.blue_duty     = lvl_b;
		res.current_index = idx;
		res.at_target     = on_aim();
		levels_due.push_back(res);
	endtask

	task automatic note_mismatch(string what);
		bad_total++;
		if (bad_total <= PRINT_CAP) begin
			$display("[%0t] result %0d: %s", $realtime, checked, what);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			fade_ms   = FADE_INTERVAL_RST;
			hold_ms   = HOLD_INTERVAL_RST;
			count_reg = COLOR_COUNT_RST;
			for (int i = 0; i < TABLE_WORDS; i++) begin
				palette[i] = COLOR_WORD_RST[i];
			end
			lvl_r   = '0;
			lvl_g   = '0;
			lvl_b   = '0;
			idx     = '0;
			black   = 1'b0;
			elapsed = '0;
			levels_due.delete();
			checked = 0;
			results_seen <= 0;
		end else begin
			// register write transfer
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[CFG_ADDR_W-1:2]))
					REG_FADE_INTERVAL: fade_ms = pwdata[CFG_INTERVAL_W-1:0];
					REG_HOLD_INTERVAL: hold_ms = pwdata[CFG_INTERVAL_W-1:0];
					REG_COLOR_COUNT:   count_reg = pwdata[INDEX_W-1:0];
					default: begin
						palette[paddr[CFG_ADDR_W-1:2] - REG_COLOR_WORD_0] = pwdata[COLOR_W-1:0];
					end
				endcase
			end
			// input transfer
			if (in_valid && in_ready) begin
				apply_item(in_data);
			end
			// result transfer
			if (out_valid === 1'b1 && out_ready) begin
				if (levels_due.size() == 0) begin
					note_mismatch($sformatf("unexpected result %h", out_data));
				end else begin
					want = levels_due.pop_front();
					checked++;
					if (out_data.red_duty !== want.red_duty)
						note_mismatch($sformatf("red_duty %0d, expected %0d",
							out_data.red_duty, want.red_duty));
					if (out_data.green_duty !== want.green_duty)
						note_mismatch($sformatf("green_duty %0d, expected %0d",
							out_data.green_duty, want.green_duty));
					if (out_data.blue_duty !== want.blue_duty)
						note_mismatch($sformatf("blue_duty %0d, expected %0d",
							out_data.blue_duty, want.blue_duty));
					if (out_data.current_index !== want.current_index)
						note_mismatch($sformatf("current_index %0d, expected %0d",
							out_data.current_index, want.current_index));
					if (out_data.at_target !== want.at_target)
						note_mismatch($sformatf("at_target %0d, expected %0d",
							out_data.at_target, want.at_target));
					results_seen <= checked;
				end
			end
		end
	end

endmodule

>>> tb/sv/rgb_color_fade_sequencer_tb.sv
// testbench top for the rgb colour fade sequencer: clock, reset, stimulus and verdict
module rgb_color_fade_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rgbcfs_pkg::*;

	localparam logic              FUNC_TICK       = 1'b0;
	localparam logic              FUNC_EVENT      = 1'b1;
	localparam logic signed [7:0] CODE_RETRY      = 8'sd0;
	localparam int                NUM_REGS        = REG_COLOR_WORD_4 + 1;
	localparam int                ITEM_W          = $bits(in_item_t);
	localparam int                RANDOM_ITEMS    = 300;
	localparam int                LONG_HOLD_MS    = 60;
	localparam int                LONG_HOLD_TICKS = 330;
	localparam int                HOLD_OFF_CYCLES = 80;
	localparam int                SETTLE_CYCLES   = 6;
	localparam int                MAX_GAP         = 12;
	localparam int                CYCLE_LIMIT     = 60000;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_ready;
	out_item_t             out_data;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [CFG_ADDR_W-1:0] paddr;
	logic [CFG_DATA_W-1:0] pwdata;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	int                    tx_gap_pct;
	int                    rx_gap_pct;
	logic                  hold_off_req;
	int                    sent_count;
	int                    results_seen;
	int                    error_count;
	int                    cycle_count;
	logic [CFG_DATA_W-1:0] settings [NUM_REGS];

	rgb_color_fade_sequencer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	rgb_color_fade_sequencer_chk u_chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.results_seen (results_seen),
		.error_count  (error_count)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// run limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("run stopped after %0d cycles", cycle_count);
		$display("Mismatches found");
		$finish;
	end

	// result side: random back-pressure, plus one long hold-off on request
	initial begin
		bit held;
		held = 1'b0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_req && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
			end
			out_ready <= ($urandom_range(0, 99) >= rx_gap_pct);
		end
	end

	function automatic in_item_t make_item(logic f, logic signed [7:0] code);
		in_item_t it;
		it.func        = f;
		it.signal_code = code;
		return it;
	endfunction

	// one input transfer, with a random gap in front of it
	task automatic send_item(input in_item_t it);
		int       gap;
		in_item_t junk;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(0, 99) < tx_gap_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) begin
				junk = ITEM_W'($urandom);
				in_data <= junk;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sent_count++;
	endtask

	// stop offering and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_seen != sent_count) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write every register from the settings array
	task automatic load_settings();
		for (int i = 0; i < NUM_REGS; i++) begin
			psel    <= 1'b1;
			penable <= 1'b0;
			pwrite  <= 1'b1;
			paddr   <= {reg_idx_t'(i), 2'b00};
			pwdata  <= settings[i];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready) @(posedge clk);
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// stimulus
	initial begin
		in_item_t it;
		int       phase_items;
		int       random_sent;
		int       phase_no;
		bit       stalled;

		arst_n       <= 1'b0;
		in_valid     <= 1'b0;
		in_data      <= '0;
		psel         <= 1'b0;
		penable      <= 1'b0;
		pwrite       <= 1'b0;
		paddr        <= '0;
		pwdata       <= '0;
		hold_off_req <= 1'b0;
		rx_gap_pct   <= 76;
		tx_gap_pct   = 37;
		sent_count   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: code extremes, ignored codes, retry from index zero
		send_item(make_item(FUNC_TICK, 8'sh7F));
		send_item(make_item(FUNC_EVENT, 8'sd1));
		send_item(make_item(FUNC_EVENT, -8'sd128));
		send_item(make_item(FUNC_EVENT, 8'sh7F));
		send_item(make_item(FUNC_EVENT, -8'sd1));
		send_item(make_item(FUNC_EVENT, CODE_RETRY));
		send_item(make_item(FUNC_TICK, -8'sd128));
		send_item(make_item(FUNC_EVENT, CODE_RETRY));
		send_item(make_item(FUNC_TICK, 8'sd0));
		drain();

		// zero intervals, count above range, mixed table: advance, wrap, fade both ways
		settings[REG_FADE_INTERVAL] = '0;
		settings[REG_HOLD_INTERVAL] = '0;
		settings[REG_COLOR_COUNT]   = 7;
		settings[REG_COLOR_WORD_0]  = CFG_DATA_W'(24'h000102);
		settings[REG_COLOR_WORD_1]  = CFG_DATA_W'(24'hFF00FF);
		settings[REG_COLOR_WORD_2]  = CFG_DATA_W'(24'h010101);
		settings[REG_COLOR_WORD_3]  = CFG_DATA_W'(24'h000000);
		settings[REG_COLOR_WORD_4]  = CFG_DATA_W'(24'h030000);
		load_settings();
		repeat (6) send_item(make_item(FUNC_TICK, -8'sd1));
		send_item(make_item(FUNC_EVENT, CODE_RETRY));
		repeat (6) send_item(make_item(FUNC_TICK, 8'sd0));

		// random phases, each with fresh settings
		phase_no    = 0;
		random_sent = 0;
		stalled     = 1'b0;
		while (random_sent < RANDOM_ITEMS) begin
			drain();
			// idling pattern moves on by thirds
			if (random_sent < RANDOM_ITEMS / 3) begin
				tx_gap_pct = 37;
				rx_gap_pct <= 76;
			end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
				tx_gap_pct = 76;
				rx_gap_pct <= 37;
			end else begin
				tx_gap_pct = 0;
				rx_gap_pct <= 0;
			end
			case ($urandom_range(0, 9))
				0:       settings[REG_FADE_INTERVAL] = CFG_DATA_W'(16'hFFFF);
				1:       settings[REG_FADE_INTERVAL] = $urandom_range(0, 16'hFFFF);
				2:       settings[REG_FADE_INTERVAL] = $urandom_range(3, 12);
				default: settings[REG_FADE_INTERVAL] = $urandom_range(0, 2);
			endcase
			if (phase_no == 2) settings[REG_FADE_INTERVAL] = CFG_DATA_W'(16'hFFFF);
			case ($urandom_range(0, 9))
				0:       settings[REG_HOLD_INTERVAL] = CFG_DATA_W'(16'hFFFF);
				1:       settings[REG_HOLD_INTERVAL] = $urandom_range(0, 16'hFFFF);
				2:       settings[REG_HOLD_INTERVAL] = $urandom_range(5, 20);
				default: settings[REG_HOLD_INTERVAL] = $urandom_range(0, 4);
			endcase
			settings[REG_COLOR_COUNT] = $urandom_range(0, 7);
			// mostly dim colours so targets are reached, now and then full range
			for (int w = REG_COLOR_WORD_0; w <= REG_COLOR_WORD_4; w++) begin
				case ($urandom_range(0, 9))
					0:       settings[w] = $urandom_range(0, 24'hFFFFFF);
					1:       settings[w] = CFG_DATA_W'(24'hFFFFFF);
					2:       settings[w] = '0;
					default: settings[w] = CFG_DATA_W'({8'($urandom_range(0, 5)),
						8'($urandom_range(0, 5)), 8'($urandom_range(0, 5))});
				endcase
			end
			load_settings();
			// long result hold-off while the sender keeps offering
			if (tx_gap_pct == 0 && !stalled) begin
				hold_off_req <= 1'b1;
				stalled = 1'b1;
			end
			phase_items = $urandom_range(15, 50);
			repeat (phase_items) begin
				it.signal_code = 8'($urandom);
				if ($urandom_range(0, 99) < 82) begin
					it.func = FUNC_TICK;
				end else begin
					it.func = FUNC_EVENT;
					if ($urandom_range(0, 1) == 0) it.signal_code = CODE_RETRY;
				end
				send_item(it);
				random_sent++;
			end
			phase_no++;
		end

		// fade to black at full speed, count out a hold interval, then advance
		drain();
		settings[REG_FADE_INTERVAL] = '0;
		settings[REG_HOLD_INTERVAL] = CFG_DATA_W'(LONG_HOLD_MS);
		settings[REG_COLOR_COUNT]   = 2;
		for (int w = REG_COLOR_WORD_0; w <= REG_COLOR_WORD_4; w++) begin
			settings[w] = '0;
		end
		load_settings();
		repeat (LONG_HOLD_TICKS) send_item(make_item(FUNC_TICK, 8'($urandom)));
		drain();

		$display("sent %0d items over %0d random setting phases, checked %0d results",
			sent_count, phase_no, results_seen);
		$display("included: output hold-off with input stall and a fade to black then hold");
		if (error_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
